// ----- hdl/assert_macros.svh -----
// assertion macros used by the checker file
// each macro samples on clk and is disabled while rst is high
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds at every clock edge
`define ASSERT_ALWAYS(name, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// condition in one cycle implies a condition in the next
`define ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/ivm_pkg.sv -----
// ----------------------------------------------------------------------------
// ivm_pkg
// types and constants shared by the interval value map modules
// ----------------------------------------------------------------------------
`default_nettype none

package ivm_pkg;

  // width of the init value register and of the entry count result
  localparam int CFG_BITS   = 8;
  localparam int COUNT_BITS = 7;

  // result status codes
  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // sequencer states
  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_INS_B,
    ST_INS_E,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/interval_value_map.sv -----
// ----------------------------------------------------------------------------
// interval_value_map
// piecewise constant map held as a sorted breakpoint table in memory
// ----------------------------------------------------------------------------
// channel   direction  handshake                 payload
// item      in         start, busy               kind, key_begin, key_end,
//                                                value, query_key
// result    out        done (one cycle strobe)   lookup_value, status,
//                                                entry_count
// config    in         cfg_valid, cfg_ready      cfg_data (init value)
//
// the table lives in two banks of one memory; an assign streams the current
// bank into the other one, one entry per cycle through the read port while
// in the scan state, and swaps banks on success. the memory read port sets
// the pace. after reset the init state writes entry 0 while busy is high.
// results cannot be stalled; a config beat resets the table and is held off
// while start is high.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_value_map #(
  parameter int CAPACITY   = 64,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          kind,
  input  wire logic [KEY_BITS-1:0]           key_begin,
  input  wire logic [KEY_BITS-1:0]           key_end,
  input  wire logic [VALUE_BITS-1:0]         value,
  input  wire logic [KEY_BITS-1:0]           query_key,
  output logic                               done,
  output logic [VALUE_BITS-1:0]              lookup_value,
  output logic [1:0]                         status,
  output logic [ivm_pkg::COUNT_BITS-1:0]     entry_count,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [ivm_pkg::CFG_BITS-1:0]  cfg_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 3);
  localparam int DW = KEY_BITS + VALUE_BITS;

  ivm_pkg::state_t state, state_next;

  logic                  bank;
  logic [CW-1:0]         used;
  logic [VALUE_BITS-1:0] init_val;
  logic                  op_lookup;
  logic [KEY_BITS-1:0]   kb, ke, cover_key;
  logic [VALUE_BITS-1:0] v, vend, last_val;
  logic                  have_last, post;
  logic [CW-1:0]         rd_idx, wr_cnt, restart;
  logic                  inflight;

  // memory ports
  logic                  mem_we;
  logic [IW:0]           mem_waddr, mem_raddr;
  logic [DW-1:0]         mem_wdata, mem_rdata;
  logic [KEY_BITS-1:0]   rk;
  logic [VALUE_BITS-1:0] rv;

  // control decode
  logic cfg_beat, item_beat, empty_item;
  logic above, at_end, stop, issue, wr_ok;
  logic [VALUE_BITS-1:0] init_ext;

  assign cfg_ready  = (state == ivm_pkg::ST_IDLE) && !start;
  assign busy       = (state != ivm_pkg::ST_IDLE);
  assign cfg_beat   = cfg_valid && cfg_ready;
  assign item_beat  = start && !busy;
  assign empty_item = !kind && (key_begin >= key_end);

  assign rk       = mem_rdata[DW-1:VALUE_BITS];
  assign rv       = mem_rdata[VALUE_BITS-1:0];
  assign above    = inflight && (rk > cover_key);
  assign at_end   = !inflight && (rd_idx >= used);
  assign stop     = (!post && above) || at_end;
  assign issue    = (state == ivm_pkg::ST_SCAN) && !stop && (rd_idx < used);
  assign wr_ok    = wr_cnt < CW'(CAPACITY);
  assign init_ext = VALUE_BITS'(cfg_data);

  ivm_mem #(
    .ADDR_BITS(IW + 1),
    .DATA_BITS(DW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ivm_pkg::ST_INIT:   state_next = ivm_pkg::ST_IDLE;
      ivm_pkg::ST_IDLE: begin
        if (item_beat && !empty_item) state_next = ivm_pkg::ST_SCAN;
      end
      ivm_pkg::ST_SCAN: begin
        if (stop) begin
          if (op_lookup || post) state_next = ivm_pkg::ST_FINISH;
          else                   state_next = ivm_pkg::ST_INS_B;
        end
      end
      ivm_pkg::ST_INS_B:  state_next = ivm_pkg::ST_INS_E;
      ivm_pkg::ST_INS_E: begin
        if (restart < used) state_next = ivm_pkg::ST_SCAN;
        else                state_next = ivm_pkg::ST_FINISH;
      end
      ivm_pkg::ST_FINISH: state_next = ivm_pkg::ST_IDLE;
      default:            state_next = ivm_pkg::ST_INIT;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {~bank, wr_cnt[IW-1:0]};
    mem_wdata = mem_rdata;
    mem_raddr = {bank, rd_idx[IW-1:0]};
    unique case (state)
      ivm_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = {bank, IW'(0)};
        mem_wdata = {KEY_BITS'(0), init_val};
      end
      ivm_pkg::ST_IDLE: begin
        mem_we    = cfg_beat;
        mem_waddr = {bank, IW'(0)};
        mem_wdata = {KEY_BITS'(0), init_ext};
      end
      ivm_pkg::ST_SCAN: begin
        // copy entries below key_begin, or everything past key_end
        if (!op_lookup && inflight && wr_ok) begin
          mem_we = post || (rk < kb);
        end
      end
      ivm_pkg::ST_INS_B: begin
        mem_we    = wr_ok && !(have_last && last_val == v);
        mem_wdata = {kb, v};
      end
      ivm_pkg::ST_INS_E: begin
        mem_we    = wr_ok && (vend != v);
        mem_wdata = {ke, vend};
      end
      ivm_pkg::ST_FINISH: mem_we = 1'b0;
      default:            mem_we = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ivm_pkg::ST_INIT;
      bank     <= 1'b0;
      used     <= CW'(1);
      init_val <= '0;
      done     <= 1'b0;
      inflight <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ivm_pkg::ST_INIT: inflight <= 1'b0;
        ivm_pkg::ST_IDLE: begin
          inflight <= 1'b0;
          if (cfg_beat) begin
            init_val <= init_ext;
            used     <= CW'(1);
          end else if (item_beat && empty_item) begin
            done <= 1'b1;
          end
        end
        ivm_pkg::ST_SCAN: inflight <= issue;
        ivm_pkg::ST_INS_B: inflight <= 1'b0;
        ivm_pkg::ST_INS_E: inflight <= 1'b0;
        ivm_pkg::ST_FINISH: begin
          done <= 1'b1;
          if (!op_lookup && wr_cnt <= CW'(CAPACITY)) begin
            bank <= ~bank;
            used <= wr_cnt;
          end
        end
        default: inflight <= 1'b0;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ivm_pkg::ST_IDLE: begin
        op_lookup <= kind;
        kb        <= key_begin;
        ke        <= key_end;
        v         <= value;
        cover_key <= kind ? query_key : key_end;
        rd_idx    <= '0;
        wr_cnt    <= '0;
        have_last <= 1'b0;
        post      <= 1'b0;
        if (item_beat && empty_item) begin
          lookup_value <= '0;
          status       <= ivm_pkg::STATUS_EMPTY;
          entry_count  <= ivm_pkg::COUNT_BITS'(used);
        end
      end
      ivm_pkg::ST_SCAN: begin
        if (issue) rd_idx <= rd_idx + CW'(1);
        if (!post && inflight && !above) begin
          vend <= rv;
          if (rk < kb) begin
            last_val  <= rv;
            have_last <= 1'b1;
          end
        end
        if (!op_lookup && inflight && (post || (!above && rk < kb))) begin
          wr_cnt <= wr_cnt + CW'(1);
        end
        // remember where the tail starts
        if (!post && above) restart <= rd_idx - CW'(1);
        else if (at_end)    restart <= used;
      end
      ivm_pkg::ST_INS_B: begin
        if (!(have_last && last_val == v)) wr_cnt <= wr_cnt + CW'(1);
      end
      ivm_pkg::ST_INS_E: begin
        if (vend != v) wr_cnt <= wr_cnt + CW'(1);
        rd_idx <= restart;
        post   <= 1'b1;
      end
      ivm_pkg::ST_FINISH: begin
        if (op_lookup) begin
          lookup_value <= vend;
          status       <= ivm_pkg::STATUS_DONE;
          entry_count  <= ivm_pkg::COUNT_BITS'(used);
        end else begin
          lookup_value <= '0;
          if (wr_cnt <= CW'(CAPACITY)) begin
            status      <= ivm_pkg::STATUS_DONE;
            entry_count <= ivm_pkg::COUNT_BITS'(wr_cnt);
          end else begin
            status      <= ivm_pkg::STATUS_FULL;
            entry_count <= ivm_pkg::COUNT_BITS'(used);
          end
        end
      end
      default: post <= post;
    endcase
  end

endmodule

`default_nettype wire

// ----- hdl/ivm_mem.sv -----
// ----------------------------------------------------------------------------
// ivm_mem
// breakpoint memory: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module ivm_mem #(
  parameter int ADDR_BITS = 7,
  parameter int DATA_BITS = 40
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [DATA_BITS-1:0] wdata,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [DATA_BITS-1:0] rdata
);

  logic [DATA_BITS-1:0] mem [2**ADDR_BITS];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/ivm_checker.sv -----
// ----------------------------------------------------------------------------
// ivm_checker
// port level checks of the interval value map, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ivm_checker #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 8
) (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      kind,
  input wire logic [KEY_BITS-1:0]       key_begin,
  input wire logic [KEY_BITS-1:0]       key_end,
  input wire logic                      done,
  input wire logic [VALUE_BITS-1:0]     lookup_value,
  input wire logic [1:0]                status,
  input wire logic [ivm_pkg::COUNT_BITS-1:0] entry_count,
  input wire logic                      cfg_valid,
  input wire logic                      cfg_ready
);

  // the table never drops below one breakpoint
  `ASSERT_ALWAYS(a_count_nonzero, !done || entry_count != '0, "entry count is zero")

  // only defined status codes leave the block
  `ASSERT_ALWAYS(a_status_code, !done || status != 2'd3, "undefined status code")

  // a nonzero lookup value only comes with a done status
  `ASSERT_ALWAYS(a_value_status, !done || lookup_value == '0 || status == ivm_pkg::STATUS_DONE, "value on failed beat")

  // an empty interval answers in the next cycle
  `ASSERT_NEXT(a_empty_fast, start && !busy && !kind && key_begin >= key_end, done && status == ivm_pkg::STATUS_EMPTY, "empty interval not answered")

  // a config beat leaves the block idle
  `ASSERT_NEXT(a_cfg_idle, cfg_valid && cfg_ready && !start, !busy, "busy after config beat")

endmodule

bind interval_value_map ivm_checker #(
  .KEY_BITS  (KEY_BITS),
  .VALUE_BITS(VALUE_BITS)
) u_ivm_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .kind        (kind),
  .key_begin   (key_begin),
  .key_end     (key_end),
  .done        (done),
  .lookup_value(lookup_value),
  .status      (status),
  .entry_count (entry_count),
  .cfg_valid   (cfg_valid),
  .cfg_ready   (cfg_ready)
);

`default_nettype wire

// ----- dv/interval_value_map_tb.sv -----
// ----------------------------------------------------------------------------
// interval_value_map_tb
// self-checking bench: a directed table, then random assigns and lookups
// checked beat by beat against a breakpoint table model kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module interval_value_map_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH      = 64;
  localparam int KEYW       = 32;
  localparam int VALW       = 8;
  localparam int STALL_MAX  = 5000;
  localparam int PHASE_ITEMS = 425;
  localparam logic KIND_ASSIGN = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic [VALW-1:0]                lookup_value;
    logic [1:0]                     status;
    logic [ivm_pkg::COUNT_BITS-1:0] entry_count;
  } map_result_t;

  typedef struct {
    logic            kind;
    logic [KEYW-1:0] key_begin;
    logic [KEYW-1:0] key_end;
    logic [VALW-1:0] value;
    logic [KEYW-1:0] query_key;
    bit              typed;
    map_result_t     res;
  } map_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic [KEYW-1:0] key_begin = '0;
  logic [KEYW-1:0] key_end = '0;
  logic [VALW-1:0] value = '0;
  logic [KEYW-1:0] query_key = '0;
  logic done;
  logic [VALW-1:0] lookup_value;
  logic [1:0] status;
  logic [ivm_pkg::COUNT_BITS-1:0] entry_count;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [ivm_pkg::CFG_BITS-1:0] cfg_data = '0;

  // model of the breakpoint table
  logic [KEYW-1:0] bp_key [DEPTH];
  logic [VALW-1:0] bp_val [DEPTH];
  int unsigned     bp_used;
  logic [VALW-1:0] init_val;

  map_result_t pending_q[$];
  map_result_t typed_q[$];
  bit          typed_flag_q[$];
  int unsigned mismatches = 0;
  int unsigned idle_pct = 0;

  interval_value_map u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .key_begin(key_begin), .key_end(key_end), .value(value), .query_key(query_key),
    .done(done), .lookup_value(lookup_value), .status(status), .entry_count(entry_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void table_clear();
    bp_key[0] = '0;
    bp_val[0] = init_val;
    bp_used = 1;
  endfunction

  function automatic int unsigned covering(logic [KEYW-1:0] k);
    int unsigned found;
    found = 0;
    for (int unsigned i = 0; i < bp_used; i++) begin
      if (bp_key[i] <= k) found = i;
      else break;
    end
    return found;
  endfunction

  // apply one item to the model table and return its result
  function automatic map_result_t apply_item(logic k, logic [KEYW-1:0] kb,
      logic [KEYW-1:0] ke, logic [VALW-1:0] v, logic [KEYW-1:0] q);
    map_result_t r;
    logic [KEYW-1:0] sk [DEPTH+2];
    logic [VALW-1:0] sv [DEPTH+2];
    logic [VALW-1:0] v_end;
    int unsigned n;
    r = '0;
    n = 0;
    if (k == KIND_LOOKUP) begin
      r.lookup_value = bp_val[covering(q)];
    end else if (kb >= ke) begin
      r.status = ivm_pkg::STATUS_EMPTY;
    end else begin
      v_end = bp_val[covering(ke)];
      for (int unsigned i = 0; i < bp_used; i++)
        if (bp_key[i] < kb) begin
          sk[n] = bp_key[i]; sv[n] = bp_val[i]; n++;
        end
      if (n == 0 || sv[n-1] != v) begin
        sk[n] = kb; sv[n] = v; n++;
      end
      if (v_end != v) begin
        sk[n] = ke; sv[n] = v_end; n++;
      end
      for (int unsigned i = 0; i < bp_used; i++)
        if (bp_key[i] > ke && n < DEPTH + 2) begin
          sk[n] = bp_key[i]; sv[n] = bp_val[i]; n++;
        end
      if (n > DEPTH) begin
        r.status = ivm_pkg::STATUS_FULL;
      end else begin
        for (int unsigned i = 0; i < n; i++) begin
          bp_key[i] = sk[i]; bp_val[i] = sv[i];
        end
        bp_used = n;
      end
    end
    r.entry_count = bp_used[ivm_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic note_mismatch(string what, longint unsigned e, longint unsigned a);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s expected %0h got %0h", $realtime, what, e, a);
  endtask

  // one item beat: hold start until accepted, then optional idle gap
  task automatic send_item(logic k, logic [KEYW-1:0] kb, logic [KEYW-1:0] ke,
      logic [VALW-1:0] v, logic [KEYW-1:0] q, bit typed, map_result_t tres);
    int unsigned gap;
    start <= 1'b1;
    kind <= k; key_begin <= kb; key_end <= ke; value <= v; query_key <= q;
    do @(posedge clk); while (busy);
    pending_q.push_back(apply_item(k, kb, ke, v, q));
    typed_q.push_back(tres);
    typed_flag_q.push_back(typed);
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // config beat: only after the pipeline has drained
  task automatic write_init(logic [ivm_pkg::CFG_BITS-1:0] d);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    init_val = d;
    table_clear();
  endtask

  function automatic map_row_t row(logic k, logic [KEYW-1:0] kb, logic [KEYW-1:0] ke,
      logic [VALW-1:0] v, logic [KEYW-1:0] q, bit typed, logic [VALW-1:0] lv,
      logic [1:0] st, int unsigned cnt);
    map_row_t r;
    r.kind = k; r.key_begin = kb; r.key_end = ke; r.value = v; r.query_key = q;
    r.typed = typed;
    r.res.lookup_value = lv; r.res.status = st;
    r.res.entry_count = cnt[ivm_pkg::COUNT_BITS-1:0];
    return r;
  endfunction

  task automatic random_item();
    logic k;
    logic [KEYW-1:0] kb, ke, q;
    logic [VALW-1:0] v;
    int unsigned mode;
    k = ($urandom_range(0, 99) < 35) ? KIND_LOOKUP : KIND_ASSIGN;
    mode = $urandom_range(0, 9);
    q = $urandom();
    v = $urandom();
    if (mode < 4) begin
      // full key range
      kb = $urandom(); ke = $urandom();
      if (kb > ke && $urandom_range(0, 3) != 0) begin
        q = kb; kb = ke; ke = q;
      end
    end else if (mode < 9) begin
      // dense region, few values so neighbors merge often
      kb = $urandom_range(0, 2000);
      ke = kb + $urandom_range(0, 150);
      if ($urandom_range(0, 19) == 0) ke = kb - $urandom_range(0, 5);
      v = $urandom_range(0, 3);
      q = $urandom_range(0, 2200);
    end else begin
      // top of the key space
      kb = 32'hFFFF_FFFF - $urandom_range(0, 50);
      ke = 32'hFFFF_FFFF - $urandom_range(0, 20);
      q = 32'hFFFF_FFFF - $urandom_range(0, 60);
    end
    send_item(k, kb, ke, v, q, 1'b0, '0);
  endtask

  // result checker
  always @(posedge clk) begin : check_results
    map_result_t e, t;
    bit tf;
    if (!rst && done) begin
      if (pending_q.size() == 0) begin
        note_mismatch("unexpected result", 0, {lookup_value, status, entry_count});
      end else begin
        e = pending_q.pop_front();
        t = typed_q.pop_front();
        tf = typed_flag_q.pop_front();
        if (tf && t != e) note_mismatch("bench table vs typed row", t, e);
        if (lookup_value !== e.lookup_value)
          note_mismatch("lookup_value", e.lookup_value, lookup_value);
        if (status !== e.status) note_mismatch("status", e.status, status);
        if (entry_count !== e.entry_count)
          note_mismatch("entry_count", e.entry_count, entry_count);
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int unsigned quiet = 0;
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_MAX) begin
      $display("interval_value_map: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    map_row_t dir[$];
    int unsigned init_vals[4];
    init_vals = '{0, 255, 0, 0};
    init_val = '0;
    table_clear();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed rows from reset state
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 32'h0, 1, 8'h00, ivm_pkg::STATUS_DONE, 1));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1, 8'h00,
                      ivm_pkg::STATUS_DONE, 1));
    dir.push_back(row(KIND_ASSIGN, 5, 5, 8'h11, 0, 1, 8'h00, ivm_pkg::STATUS_EMPTY, 1));
    dir.push_back(row(KIND_ASSIGN, 32'hFFFF_FFFF, 0, 8'h22, 0, 1, 8'h00,
                      ivm_pkg::STATUS_EMPTY, 1));
    dir.push_back(row(KIND_ASSIGN, 0, 32'hFFFF_FFFF, 8'hFF, 0, 1, 8'h00,
                      ivm_pkg::STATUS_DONE, 2));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 32'hFFFF_FFFF, 1, 8'h00,
                      ivm_pkg::STATUS_DONE, 2));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 32'hFFFF_FFFE, 1, 8'hFF,
                      ivm_pkg::STATUS_DONE, 2));
    dir.push_back(row(KIND_ASSIGN, 100, 200, 8'hFF, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 100, 200, 8'h5A, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 200, 300, 8'h5A, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 150, 250, 8'hA5, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 149, 0, 0, 0, 0));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 250, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 120, 280, 8'hFF, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 0, 1, 8'h00, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 8'h00, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_ASSIGN, 0, 32'hFFFF_FFFF, 8'h00, 0, 0, 0, 0, 0));
    dir.push_back(row(KIND_LOOKUP, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0));
    foreach (dir[i])
      send_item(dir[i].kind, dir[i].key_begin, dir[i].key_end, dir[i].value,
                dir[i].query_key, dir[i].typed, dir[i].res);

    // fill the table with many small intervals to reach the full status
    for (int i = 0; i < 40; i++)
      send_item(KIND_ASSIGN, 1000 + 10 * i, 1005 + 10 * i, (i % 2) ? 8'h7 : 8'h9,
                0, 0, '0);

    // random phases with different idle rates and init values
    init_vals[2] = $urandom_range(1, 254);
    init_vals[3] = $urandom_range(0, 255);
    for (int p = 0; p < 4; p++) begin
      write_init(init_vals[p][ivm_pkg::CFG_BITS-1:0]);
      idle_pct = (p == 1) ? 70 : (p == 3) ? 27 : 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain();
        random_item();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("interval_value_map: match");
    end else begin
      $display("interval_value_map: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- sim.f -----
+incdir+hdl
hdl/ivm_pkg.sv
hdl/ivm_mem.sv
hdl/interval_value_map.sv
hdl/ivm_checker.sv
dv/interval_value_map_tb.sv
